FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion checks included by the hop ratio RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that cond never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/dhhr_pkg.sv
// ----------------------------------------------------------------------------
// dhhr_pkg
// Types, codes and helpers of the doublon-holon hop ratio block.
// ----------------------------------------------------------------------------
package dhhr_pkg;

   localparam int SITE_COUNT_DEF    = 256;
   localparam int MAX_NEIGHBORS_DEF = 16;
   localparam int SHELL_COUNT_DEF   = 3;

   localparam int SITE_W    = 8;
   localparam int OCC_W     = 2;
   localparam int SHELL_W   = 2;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 5;
   localparam int PWR_W     = 7;
   localparam int ACC_W     = 9;
   localparam int CSR_W     = 2;
   localparam int POWER_LIMIT = 40;

   typedef enum logic [1:0] {
      KIND_OCC   = 2'd0,
      KIND_SLOT  = 2'd1,
      KIND_COUNT = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_ENABLE = 1'b0,
      CSR_SHELLS = 1'b1
   } csr_index_type;

   localparam logic [OCC_W-1:0] OCC_HOLON   = 2'd0;
   localparam logic [OCC_W-1:0] OCC_SINGLE  = 2'd1;
   localparam logic [OCC_W-1:0] OCC_DOUBLON = 2'd2;

   function automatic logic signed [PWR_W-1:0] sat_power(input logic signed [ACC_W-1:0] p);
      logic signed [PWR_W-1:0] r;
      if (p > ACC_W'(POWER_LIMIT)) begin
         r = PWR_W'(POWER_LIMIT);
      end else if (p < -ACC_W'(POWER_LIMIT)) begin
         r = -PWR_W'(POWER_LIMIT);
      end else begin
         r = p[PWR_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/dhhr_ram.sv
// ----------------------------------------------------------------------------
// dhhr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dhhr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/doublon_holon_hop_ratio.sv
// ----------------------------------------------------------------------------
// doublon_holon_hop_ratio
// Per-shell doublon-holon exponents of a hop, walked over stored neighbor lists.
// ----------------------------------------------------------------------------
// One request is handled at a time. Write requests go from idle straight to the
// done state. A query runs three memories (occupancy, counts, neighbor lists)
// one read at a time: per shell in use and for each of the two sites it walks
// the site's neighbor list and, for each qualifying neighbor, that neighbor's
// list, then finishes in the done state.
// A disabled projector or a same-site hop answers without a walk. After reset a
// clearing pass over every occupancy and count entry empties occupancy and
// counts before the first request is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module doublon_holon_hop_ratio #(
   parameter int SITE_COUNT    = dhhr_pkg::SITE_COUNT_DEF,
   parameter int MAX_NEIGHBORS = dhhr_pkg::MAX_NEIGHBORS_DEF,
   parameter int SHELL_COUNT   = dhhr_pkg::SHELL_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [dhhr_pkg::SITE_W-1:0]         req_site,
   input  logic [dhhr_pkg::SITE_W-1:0]         req_other_site,
   input  logic [dhhr_pkg::OCC_W-1:0]          req_occupancy,
   input  logic [dhhr_pkg::SHELL_W-1:0]        req_shell,
   input  logic [dhhr_pkg::SLOT_W-1:0]         req_slot,
   input  logic [dhhr_pkg::COUNT_W-1:0]        req_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_answer,
   output logic signed [dhhr_pkg::PWR_W-1:0]   rsp_power_shell_one,
   output logic signed [dhhr_pkg::PWR_W-1:0]   rsp_power_shell_two,
   output logic signed [dhhr_pkg::PWR_W-1:0]   rsp_power_shell_three,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [dhhr_pkg::CSR_W-1:0]          csr_wdata
);
   import dhhr_pkg::*;

   localparam int AW   = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;
   localparam int SD   = 1 << AW;
   localparam int NW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int CNW  = $clog2(MAX_NEIGHBORS + 1);
   localparam int CAW  = AW + SHELL_W;
   localparam int NAW  = CAW + NW;

   typedef enum logic [10:0] {
      S_CLR   = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_CEN   = 11'b00000000100,
      S_CEN_W = 11'b00000001000,
      S_A     = 11'b00000010000,
      S_A_W   = 11'b00000100000,
      S_NN    = 11'b00001000000,
      S_B     = 11'b00010000000,
      S_B_W   = 11'b00100000000,
      S_M     = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic              enable_ff, enable_in;
   logic [CSR_W-1:0]  shells_ff, shells_in;
   logic [SITE_W-1:0] fr_ff, fr_in, to_ff, to_in, nn_ff, nn_in, mm_ff, mm_in;
   logic [1:0]        sh_ff, sh_in, used_ff, used_in;
   logic              dst_ff, dst_in, alt_ff, alt_in, any_ff, any_in, ans_ff, ans_in;
   logic [CNW-1:0]    na_ff, na_in, nb_ff, nb_in, a_ff, a_in, b_ff, b_in;
   logic [CNW-1:0]    inner_ff, inner_in;
   logic signed [ACC_W-1:0] p_ff, p_in, p_adj;
   logic signed [PWR_W-1:0] pw_ff [3];
   logic signed [PWR_W-1:0] pw_in [3];
   logic [CAW-1:0]    clr_ff, clr_in;
   logic              occ_rng_ff;
   logic              rsp_valid_ff, rsp_valid_in, rsp_ans_ff, rsp_ans_in;
   logic signed [PWR_W-1:0] rsp_pw_ff [3];
   logic signed [PWR_W-1:0] rsp_pw_in [3];

   logic              accept, site_ok, shell_ok, slot_ok;
   logic [1:0]        used_c;
   logic [COUNT_W-1:0] cnt_sat;
   logic [SITE_W-1:0] occ_raddr8, nbr_base8;
   logic [CNW-1:0]    nbr_idx;
   logic [OCC_W-1:0]  occ_eff;
   logic [CNW-1:0]    cnt_eff;
   logic              e_dbl, e_hol, nn_eq, mm_eq, qual, term;

   logic              occ_we, cnt_we, nbr_we;
   logic [AW-1:0]     occ_waddr;
   logic [OCC_W-1:0]  occ_wdata, occ_rdata;
   logic [CAW-1:0]    cnt_waddr;
   logic [CNW-1:0]    cnt_wdata, cnt_rdata;
   logic [NAW-1:0]    nbr_waddr, nbr_raddr;
   logic [SITE_W-1:0] nbr_rdata;

   dhhr_ram #(.WIDTH(OCC_W), .DEPTH(SD)) u_occ (
      .clock(clock), .wr_en(occ_we), .wr_addr(occ_waddr), .wr_data(occ_wdata),
      .rd_addr(AW'(occ_raddr8)), .rd_data(occ_rdata)
   );

   dhhr_ram #(.WIDTH(CNW), .DEPTH(SD * 4)) u_cnt (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr({AW'(occ_raddr8), sh_ff}), .rd_data(cnt_rdata)
   );

   dhhr_ram #(.WIDTH(SITE_W), .DEPTH(SD * 4 * (1 << NW))) u_nbr (
      .clock(clock), .wr_en(nbr_we), .wr_addr(nbr_waddr), .wr_data(req_other_site),
      .rd_addr(nbr_raddr), .rd_data(nbr_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign site_ok   = 32'(req_site) < SITE_COUNT;
   assign shell_ok  = 32'(req_shell) < SHELL_COUNT;
   assign slot_ok   = 32'(req_slot) < MAX_NEIGHBORS;
   assign cnt_sat   = (32'(req_count) > MAX_NEIGHBORS) ? COUNT_W'(MAX_NEIGHBORS) : req_count;

   always_comb begin
      used_c = (shells_ff == 2'd0) ? 2'd1 : shells_ff;
      if (32'(used_c) > SHELL_COUNT) begin
         used_c = 2'(SHELL_COUNT);
      end
   end

   // memory write side: clearing pass, else the accepted write request
   always_comb begin
      if (state_ff == S_CLR) begin
         occ_we    = 1'b1;
         cnt_we    = 1'b1;
         occ_waddr = clr_ff[CAW-1:SHELL_W];
         cnt_waddr = clr_ff;
         occ_wdata = OCC_HOLON;
         cnt_wdata = '0;
      end else begin
         occ_we    = accept && (req_kind == KIND_OCC) && site_ok;
         cnt_we    = accept && (req_kind == KIND_COUNT) && site_ok && shell_ok;
         occ_waddr = AW'(req_site);
         cnt_waddr = {AW'(req_site), req_shell};
         occ_wdata = req_occupancy;
         cnt_wdata = CNW'(cnt_sat);
      end
      nbr_we    = accept && (req_kind == KIND_SLOT) && site_ok && shell_ok && slot_ok;
      nbr_waddr = {AW'(req_site), req_shell, NW'(req_slot)};
   end

   // memory read side
   always_comb begin
      unique case (state_ff) inside
         S_A_W, S_B_W: occ_raddr8 = nbr_rdata;
         default:      occ_raddr8 = dst_ff ? to_ff : fr_ff;
      endcase
      nbr_base8 = (state_ff == S_A) ? (dst_ff ? to_ff : fr_ff) : nn_ff;
      nbr_idx   = (state_ff == S_A) ? a_ff : b_ff;
      nbr_raddr = {AW'(nbr_base8), sh_ff, NW'(nbr_idx)};
   end

   assign occ_eff = occ_rng_ff ? occ_rdata : OCC_SINGLE;
   assign cnt_eff = occ_rng_ff ? cnt_rdata : '0;
   assign e_dbl   = (occ_eff == OCC_DOUBLON);
   assign e_hol   = (occ_eff == OCC_HOLON);
   assign nn_eq   = (nn_ff == fr_ff);
   assign mm_eq   = (mm_ff == fr_ff);

   always_comb begin
      case ({dst_ff, alt_ff})
         2'b01:   qual = e_hol;
         2'b00:   qual = e_dbl;
         2'b11:   qual = !nn_eq && e_dbl;
         default: qual = e_hol || (nn_eq && !e_dbl);
      endcase
      case ({dst_ff, alt_ff})
         2'b01:   term = e_dbl;
         2'b00:   term = e_hol;
         2'b11:   term = mm_eq ? !e_dbl : e_hol;
         default: term = mm_eq ? 1'b0 : e_dbl;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      shells_in    = shells_ff;
      fr_in        = fr_ff;
      to_in        = to_ff;
      nn_in        = nn_ff;
      mm_in        = mm_ff;
      sh_in        = sh_ff;
      used_in      = used_ff;
      dst_in       = dst_ff;
      alt_in       = alt_ff;
      any_in       = any_ff;
      ans_in       = ans_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      inner_in     = inner_ff;
      p_in         = p_ff;
      pw_in        = pw_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ans_in   = rsp_ans_ff;
      rsp_pw_in    = rsp_pw_ff;
      p_adj        = alt_ff ? p_ff - ACC_W'(1) : p_ff + ACC_W'(1);

      if (csr_write) begin
         case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            default:    shells_in = csr_wdata;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + CAW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               fr_in    = req_site;
               to_in    = req_other_site;
               pw_in    = '{default: '0};
               sh_in    = 2'd0;
               dst_in   = 1'b0;
               p_in     = '0;
               used_in  = used_c;
               ans_in   = (req_kind == KIND_QUERY);
               state_in = S_DONE;
               if ((req_kind == KIND_QUERY) && enable_ff && (req_site != req_other_site)) begin
                  state_in = S_CEN;
               end
            end
         end
         S_CEN: begin
            state_in = S_CEN_W;
         end
         S_CEN_W: begin
            alt_in   = dst_ff ? e_hol : e_dbl;
            na_in    = cnt_eff;
            a_in     = '0;
            any_in   = 1'b0;
            state_in = S_A;
         end
         S_A: begin
            if (a_ff == na_ff) begin
               if (!dst_ff) begin
                  if (!any_ff) begin
                     p_in = p_adj;
                  end
                  dst_in   = 1'b1;
                  state_in = S_CEN;
               end else begin
                  pw_in[sh_ff] = sat_power(any_ff ? p_ff : p_adj);
                  p_in   = '0;
                  dst_in = 1'b0;
                  sh_in  = sh_ff + 2'd1;
                  state_in = (sh_ff + 2'd1 == used_ff) ? S_DONE : S_CEN;
               end
            end else begin
               state_in = S_A_W;
            end
         end
         S_A_W: begin
            nn_in    = nbr_rdata;
            state_in = S_NN;
         end
         S_NN: begin
            nb_in = cnt_eff;
            if (qual) begin
               any_in   = 1'b1;
               b_in     = '0;
               inner_in = '0;
               state_in = S_B;
            end else begin
               a_in     = a_ff + CNW'(1);
               state_in = S_A;
            end
         end
         S_B: begin
            if (b_ff == nb_ff) begin
               if (alt_ff && (inner_ff == CNW'(1))) begin
                  p_in = p_ff + ACC_W'(1);
               end else if (!alt_ff && (inner_ff == '0)) begin
                  p_in = p_ff - ACC_W'(1);
               end
               a_in     = a_ff + CNW'(1);
               state_in = S_A;
            end else begin
               state_in = S_B_W;
            end
         end
         S_B_W: begin
            mm_in    = nbr_rdata;
            state_in = S_M;
         end
         S_M: begin
            inner_in = inner_ff + CNW'(term);
            b_in     = b_ff + CNW'(1);
            state_in = S_B;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ans_in   = ans_ff;
               rsp_pw_in    = pw_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         enable_ff    <= 1'b0;
         shells_ff    <= 2'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         enable_ff    <= enable_in;
         shells_ff    <= shells_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fr_ff      <= fr_in;
      to_ff      <= to_in;
      nn_ff      <= nn_in;
      mm_ff      <= mm_in;
      sh_ff      <= sh_in;
      used_ff    <= used_in;
      dst_ff     <= dst_in;
      alt_ff     <= alt_in;
      any_ff     <= any_in;
      ans_ff     <= ans_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      inner_ff   <= inner_in;
      p_ff       <= p_in;
      pw_ff      <= pw_in;
      rsp_ans_ff <= rsp_ans_in;
      rsp_pw_ff  <= rsp_pw_in;
      occ_rng_ff <= 32'(occ_raddr8) < SITE_COUNT;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_is_answer         = rsp_ans_ff;
   assign rsp_power_shell_one   = rsp_pw_ff[0];
   assign rsp_power_shell_two   = rsp_pw_ff[1];
   assign rsp_power_shell_three = rsp_pw_ff[2];

   `ASSERT_CLK(a_walk_bound, clock, reset, (state_ff == S_A) |-> (a_ff <= na_ff), "outer walk overran list")
   `ASSERT_CLK(a_inner_bound, clock, reset, (state_ff == S_B) |-> ((b_ff <= nb_ff) && (inner_ff <= b_ff)), "inner walk overran list")
   `ASSERT_CLK(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "response without finished request")
   `ASSERT_NEVER(a_no_accept_in_clear, clock, reset, (state_ff == S_CLR) && req_valid && !req_stall, "request taken during clearing pass")

endmodule

FILE: dv/doublon_holon_hop_ratio_tb.sv
// ----------------------------------------------------------------------------
// doublon_holon_hop_ratio_tb
// Self-checking bench for the doublon-holon hop ratio block: loads occupancy
// and neighbor lists, fires hop queries under several register settings and
// checks every response against an in-bench model of the shell exponents,
// with random idling on both request and response sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module doublon_holon_hop_ratio_tb;
   import dhhr_pkg::*;

   typedef struct {
      logic                    is_answer;
      logic signed [PWR_W-1:0] pw [3];
   } hop_powers_type;

   class hop_ratio_board;
      bit [1:0]       occ_mem [256];
      bit [7:0]       nbr_mem [256][3][16];
      bit [4:0]       cnt_mem [256][3];
      bit             enable;
      bit [1:0]       shells;
      hop_powers_type pending [$];
      int             errors;

      function new();
         foreach (occ_mem[i]) occ_mem[i] = OCC_HOLON;
         foreach (cnt_mem[i, j]) cnt_mem[i][j] = '0;
         enable = 0;
         shells = 1;
         errors = 0;
      endfunction

      function bit dbl(int s);
         return occ_mem[s] == OCC_DOUBLON;
      endfunction

      function bit hol(int s);
         return occ_mem[s] == OCC_HOLON;
      endfunction

      function int shell_power(int sh, int fr, int to);
         int p, na, nb, nh, nd, nn, mm;
         bit made;
         p = 0;
         na = int'(cnt_mem[fr][sh]);
         if (dbl(fr)) begin
            nh = 0;
            for (int a = 0; a < na; a++) begin
               nn = int'(nbr_mem[fr][sh][a]);
               if (!hol(nn)) continue;
               nh++;
               nd = 0;
               nb = int'(cnt_mem[nn][sh]);
               for (int b = 0; b < nb; b++) nd += dbl(int'(nbr_mem[nn][sh][b]));
               if (nd == 1) p++;
            end
            if (nh == 0) p--;
         end else begin
            nd = 0;
            for (int a = 0; a < na; a++) begin
               nn = int'(nbr_mem[fr][sh][a]);
               if (!dbl(nn)) continue;
               nd++;
               nh = 0;
               nb = int'(cnt_mem[nn][sh]);
               for (int b = 0; b < nb; b++) nh += hol(int'(nbr_mem[nn][sh][b]));
               if (nh == 0) p--;
            end
            if (nd == 0) p++;
         end
         na = int'(cnt_mem[to][sh]);
         if (hol(to)) begin
            nd = 0;
            for (int a = 0; a < na; a++) begin
               nn = int'(nbr_mem[to][sh][a]);
               if (nn == fr || !dbl(nn)) continue;
               nd++;
               nh = 0;
               nb = int'(cnt_mem[nn][sh]);
               for (int b = 0; b < nb; b++) begin
                  mm = int'(nbr_mem[nn][sh][b]);
                  if (mm == fr) nh += !dbl(mm);
                  else nh += hol(mm);
               end
               if (nh == 1) p++;
            end
            if (nd == 0) p--;
         end else begin
            nh = 0;
            for (int a = 0; a < na; a++) begin
               nn = int'(nbr_mem[to][sh][a]);
               made = (nn == fr) && !dbl(nn);
               if (!(hol(nn) || made)) continue;
               nh++;
               nd = 0;
               nb = int'(cnt_mem[nn][sh]);
               for (int b = 0; b < nb; b++) begin
                  mm = int'(nbr_mem[nn][sh][b]);
                  if (mm == fr) continue;
                  nd += dbl(mm);
               end
               if (nd == 0) p--;
            end
            if (nh == 0) p++;
         end
         if (p > POWER_LIMIT) p = POWER_LIMIT;
         if (p < -POWER_LIMIT) p = -POWER_LIMIT;
         return p;
      endfunction

      function void note_request(kind_type k, int site, int other, bit [1:0] occ,
                                 int sh, int slot, int cnt);
         hop_powers_type e;
         int used;
         e.is_answer = 0;
         foreach (e.pw[i]) e.pw[i] = '0;
         case (k)
            KIND_OCC: occ_mem[site] = occ;
            KIND_SLOT: if (sh < 3) nbr_mem[site][sh][slot] = 8'(other);
            KIND_COUNT: if (sh < 3) cnt_mem[site][sh] = (cnt > 16) ? 5'd16 : 5'(cnt);
            default: begin
               e.is_answer = 1;
               if (enable && site != other) begin
                  used = (shells == 0) ? 1 : int'(shells);
                  for (int s = 0; s < used; s++)
                     e.pw[s] = PWR_W'(shell_power(s, site, other));
               end
            end
         endcase
         pending = {pending, e};
      endfunction

      function void check_response(logic ans, logic signed [PWR_W-1:0] p1,
                                   logic signed [PWR_W-1:0] p2,
                                   logic signed [PWR_W-1:0] p3);
         hop_powers_type e;
         if (pending.size() == 0) begin
            $error("unexpected response is_answer=%0d", ans);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (ans !== e.is_answer) begin
            $error("is_answer: expected %0d, got %0d", e.is_answer, ans);
            errors++;
         end
         if (p1 !== e.pw[0]) begin
            $error("power_shell_one: expected %0d, got %0d", e.pw[0], p1);
            errors++;
         end
         if (p2 !== e.pw[1]) begin
            $error("power_shell_two: expected %0d, got %0d", e.pw[1], p2);
            errors++;
         end
         if (p3 !== e.pw[2]) begin
            $error("power_shell_three: expected %0d, got %0d", e.pw[2], p3);
            errors++;
         end
      endfunction
   endclass

   localparam longint CYCLE_LIMIT = 20_000_000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_kind;
   logic [SITE_W-1:0]       req_site;
   logic [SITE_W-1:0]       req_other_site;
   logic [OCC_W-1:0]        req_occupancy;
   logic [SHELL_W-1:0]      req_shell;
   logic [SLOT_W-1:0]       req_slot;
   logic [COUNT_W-1:0]      req_count;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_is_answer;
   logic signed [PWR_W-1:0] rsp_power_shell_one;
   logic signed [PWR_W-1:0] rsp_power_shell_two;
   logic signed [PWR_W-1:0] rsp_power_shell_three;
   logic                    csr_write;
   logic                    csr_index;
   logic [CSR_W-1:0]        csr_wdata;

   hop_ratio_board board;
   bit             calm;
   bit             filled [256][3][16];
   longint         cycles;

   doublon_holon_hop_ratio DUT (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // response side: check at the rising edge, move stall at the falling edge
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_response(rsp_is_answer, rsp_power_shell_one,
                                 rsp_power_shell_two, rsp_power_shell_three);
         @(negedge clock);
         if (burst > 0) burst--;
         else if (!calm && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 11);
         rsp_stall = (burst > 0);
      end
   end

   task automatic send(kind_type k, int site, int other, int occ, int sh,
                       int slot, int cnt);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid      = 1;
      req_kind       = k;
      req_site       = SITE_W'(site);
      req_other_site = SITE_W'(other);
      req_occupancy  = OCC_W'(occ);
      req_shell      = SHELL_W'(sh);
      req_slot       = SLOT_W'(slot);
      req_count      = COUNT_W'(cnt);
      do @(posedge clock); while (req_stall);
      board.note_request(k, site, other, OCC_W'(occ), sh, slot, cnt);
      if (k == KIND_SLOT && sh < 3) filled[site][sh][slot] = 1'b1;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   task automatic set_regs(bit en, bit [1:0] sh);
      drain();
      csr_write = 1;
      csr_index = CSR_ENABLE;
      csr_wdata = CSR_W'(en);
      @(negedge clock);
      csr_index = CSR_SHELLS;
      csr_wdata = sh;
      @(negedge clock);
      csr_write = 0;
      board.enable = en;
      board.shells = sh;
   endtask

   function automatic int pick_site();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 11);
   endfunction

   // fill any unwritten slots below the new length before it is set
   task automatic set_count(int site, int sh, int cnt);
      int eff;
      eff = (cnt > 16) ? 16 : cnt;
      if (sh < 3)
         for (int i = 0; i < eff; i++)
            if (!filled[site][sh][i]) send(KIND_SLOT, site, pick_site(), 0, sh, i, 0);
      send(KIND_COUNT, site, $urandom_range(0, 255), $urandom_range(0, 3), sh,
           $urandom_range(0, 15), cnt);
   endtask

   task automatic random_request();
      int r, cnt;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         send(KIND_OCC, pick_site(), $urandom_range(0, 255), $urandom_range(0, 3),
              $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 31));
      end else if (r < 48) begin
         cnt = ($urandom_range(0, 39) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 5);
         set_count(pick_site(), ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2), cnt);
      end else if (r < 62) begin
         send(KIND_SLOT, pick_site(), pick_site(), $urandom_range(0, 3),
              $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 31));
      end else begin
         send(KIND_QUERY, pick_site(), pick_site(), $urandom_range(0, 3),
              $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 31));
      end
   endtask

   initial begin
      bit          en_seq [5] = '{1, 1, 1, 0, 1};
      bit [1:0]    sh_seq [5] = '{1, 0, 2, 2, 3};
      board          = new();
      calm           = 0;
      reset          = 1;
      req_valid      = 0;
      req_kind       = KIND_OCC;
      req_site       = '0;
      req_other_site = '0;
      req_occupancy  = '0;
      req_shell      = '0;
      req_slot       = '0;
      req_count      = '0;
      csr_write      = 0;
      csr_index      = CSR_ENABLE;
      csr_wdata      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send(KIND_QUERY, 1, 2, 0, 0, 0, 0);
      set_regs(1, 3);
      send(KIND_OCC, 0, 0, OCC_DOUBLON, 0, 0, 0);
      send(KIND_OCC, 2, 0, OCC_SINGLE, 0, 0, 0);
      send(KIND_OCC, 3, 0, 3, 0, 0, 0);
      send(KIND_OCC, 255, 255, OCC_DOUBLON, 3, 15, 31);
      send(KIND_SLOT, 0, 1, 0, 0, 0, 0);
      send(KIND_SLOT, 0, 2, 0, 0, 1, 0);
      send(KIND_SLOT, 1, 0, 0, 0, 0, 0);
      send(KIND_SLOT, 2, 255, 0, 0, 0, 0);
      send(KIND_SLOT, 4, 9, 0, 3, 15, 0);
      send(KIND_COUNT, 0, 0, 0, 0, 0, 2);
      send(KIND_COUNT, 1, 0, 0, 0, 0, 1);
      send(KIND_COUNT, 5, 0, 0, 3, 0, 16);
      send(KIND_COUNT, 2, 0, 0, 0, 0, 1);
      set_count(255, 1, 31);
      set_count(0, 2, 16);
      send(KIND_QUERY, 0, 1, 0, 0, 0, 0);
      send(KIND_QUERY, 1, 0, 0, 0, 0, 0);
      send(KIND_QUERY, 2, 3, 0, 0, 0, 0);
      send(KIND_QUERY, 255, 0, 0, 0, 0, 0);
      send(KIND_QUERY, 0, 255, 0, 0, 0, 0);
      send(KIND_QUERY, 7, 7, 0, 0, 0, 0);
      set_count(0, 0, 0);

      for (int ph = 0; ph < 5; ph++) begin
         set_regs(en_seq[ph], sh_seq[ph]);
         for (int i = 0; i < 200; i++) begin
            if (ph == 4 && i > 100) calm = 1;
            random_request();
         end
      end

      req_valid = 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
